// ----- src/dynamic_biquad_lowpass_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dynamic biquad low-pass block
// Two concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_BIQUAD_LOWPASS_ASSERT_SVH
`define DYNAMIC_BIQUAD_LOWPASS_ASSERT_SVH
`ifndef SYNTHESIS
`define DBL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dynamic_biquad_lowpass: assertion failed");
`define DBL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dynamic_biquad_lowpass: assertion failed");
`else
`define DBL_ASSERT_IMPL(lbl, ante, cons)
`define DBL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/dbl_pkg.sv -----
// ----------------------------------------------------------------------------
// dbl_pkg
// Widths, fixed-point constants, sequencer states and shared types.
// ----------------------------------------------------------------------------
package dbl_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 30;
  localparam int CUTOFF_BITS    = 24;
  localparam int STEP_BITS      = 16;
  localparam int MUL_W          = 33;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int ACC_W          = PROD_W + 2;
  localparam int DIV_W          = 64;
  localparam int DEN_W          = 32;
  localparam int SHORT_BITS     = 40;

  localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = 24'd2560;
  localparam logic [32:0] PI_Q29     = 33'd1686629713;
  localparam logic [32:0] PI_HALF    = PI_Q29 >> 1;
  localparam logic [32:0] W0_CLAMP   = 33'd128000000;
  localparam logic [32:0] W0_HALF    = W0_CLAMP >> 1;
  localparam logic [32:0] INV_SQRT2  = 33'd759250125;
  localparam logic [32:0] ONE_Q30    = 33'd1073741824;

  // The clamp point is 2^13 * 15625; the odd factor is divided out by a
  // reciprocal multiply with floor(2^45 / 15625) and a small correction.
  localparam logic [13:0] W0_DIVISOR = 14'd15625;
  localparam logic [31:0] W0_RECIP   = 32'd2251799813;

  typedef enum logic [4:0] {
    S_IDLE, S_P_MUL, S_P_CLAMP, S_W0_MUL, S_W0_REC, S_W0_FIX,
    S_T_MUL1, S_T_MUL2, S_T_REC, S_T_FIX, S_A_MUL, S_ALPHA,
    S_B1_DIV, S_B1_WAIT, S_A1_DIV, S_A1_WAIT, S_A2_DIV, S_A2_WAIT,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_SAT, S_OUT
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Divisor of a Taylor step: (n+1)*(n+2).
  function automatic logic [7:0] taylor_den(input logic [3:0] n);
    logic [7:0] a;
    logic [7:0] b;
    a = {4'd0, n} + 8'd1;
    b = {4'd0, n} + 8'd2;
    return a * b;
  endfunction

  // floor(2^32 / ((n+1)*(n+2))) for the Taylor step divisors.
  function automatic logic [31:0] taylor_recip(input logic [3:0] n);
    logic [31:0] r;
    case (n)
      4'd0:    r = 32'd2147483648;
      4'd1:    r = 32'd715827882;
      4'd2:    r = 32'd357913941;
      4'd3:    r = 32'd214748364;
      4'd4:    r = 32'd143165576;
      4'd5:    r = 32'd102261126;
      4'd6:    r = 32'd76695844;
      4'd7:    r = 32'd59652323;
      4'd8:    r = 32'd47721858;
      4'd9:    r = 32'd39045157;
      4'd10:   r = 32'd32537631;
      4'd11:   r = 32'd27531841;
      4'd12:   r = 32'd23598721;
      4'd13:   r = 32'd20452225;
      4'd14:   r = 32'd17895697;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/dbl_mul.sv -----
// ----------------------------------------------------------------------------
// dbl_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module dbl_mul (
  input  logic                              clk,
  input  logic signed [dbl_pkg::MUL_W-1:0]  a,
  input  logic signed [dbl_pkg::MUL_W-1:0]  b,
  output logic signed [dbl_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ----- src/dbl_div.sv -----
// ----------------------------------------------------------------------------
// dbl_div
// Restoring divider, one quotient bit per cycle, long or short numerator.
// ----------------------------------------------------------------------------
module dbl_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          short_op,
  input  logic [dbl_pkg::DIV_W-1:0]     num,
  input  logic [dbl_pkg::DEN_W-1:0]     den,
  output dbl_pkg::div_stat_t            stat,
  output logic [dbl_pkg::DIV_W-1:0]     quot
);
  import dbl_pkg::*;

  logic [DIV_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [5:0]       cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_dif;
  logic             ge;

  // Quotient bits shift into the low end of the numerator register.
  assign rem_sh  = {rem, work[DIV_W-1]};
  assign rem_dif = rem_sh - {1'b0, dvs};
  assign ge      = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= short_op ? {num[SHORT_BITS-1:0], {(DIV_W-SHORT_BITS){1'b0}}} : num;
      rem  <= '0;
      dvs  <= den;
      cnt  <= short_op ? 6'(SHORT_BITS - 1) : 6'(DIV_W - 1);
    end else if (busy) begin
      work <= {work[DIV_W-2:0], ge};
      rem  <= ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt  <= cnt - 6'd1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = work;

endmodule

// ----- src/dynamic_biquad_lowpass.sv -----
// ----------------------------------------------------------------------------
// dynamic_biquad_lowpass
// Butterworth biquad low-pass whose coefficients are rebuilt for every word with a nonzero time step.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                    Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  sample, time_step
//   m_axis    out        m_axis_tvalid/m_axis_tready  filtered
//   cfg       in         cfg_valid/cfg_ready          cutoff
//
// A word with a nonzero time step is worked, from acceptance until its result
// is loaded into the output register, in this order: the angle, the fifteen
// sine and cosine Taylor terms, alpha, the three 64-bit coefficient divides,
// the filter products, and rounding and loading. The divides by constants use
// reciprocal multiplies. A word with a zero time step goes from the idle state
// straight to loading, with its sample passed through. The input side is ready
// only in the idle state. Reset is synchronous and clears the cutoff to 2560,
// the history and the output valid flag. A new word is taken while the
// previous result still waits; its own result then stays in the sequencer
// until the output register has been handed over.
//
`include "dynamic_biquad_lowpass_assert.svh"

module dynamic_biquad_lowpass (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [23:0] sample, [39:24] time_step
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [23:0] filtered
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [dbl_pkg::CUTOFF_BITS-1:0] cfg_data
);
  import dbl_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

  seq_state_t state;
  seq_state_t state_next;

  // Configuration and history.
  logic [CUTOFF_BITS-1:0]        cutoff;
  logic signed [SAMPLE_BITS-1:0] x;
  logic [STEP_BITS-1:0]          dt;
  logic signed [SAMPLE_BITS-1:0] in1, in2, out1, out2;
  logic signed [SAMPLE_BITS-1:0] y;
  logic [SAMPLE_BITS-1:0]        out_data;
  logic                          out_valid;

  // Angle and series state.
  logic [26:0]        p;
  logic [31:0]        t;
  logic               neg_cos;
  logic [32:0]        term;
  logic signed [34:0] tsum;
  logic [3:0]         n;
  logic [3:0]         k;
  logic               odd;
  logic [30:0]        s;
  logic signed [31:0] c;

  // Coefficients.
  logic [30:0]        alpha;
  logic [31:0]        den;
  logic [32:0]        b0, b1;
  logic signed [32:0] na1, na2;
  logic signed [ACC_W-1:0] acc;

  // Shared units.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     div_start, div_short;
  logic [DIV_W-1:0]         div_num, div_q;
  logic [DEN_W-1:0]         div_den;
  div_stat_t                div_st;

  logic                       in_fire;
  logic                       out_free;
  logic signed [34:0]         tsum_upd;
  logic                       taylor_last;
  logic [32:0]                w0q, w0f;
  logic [32:0]                rd_v;
  logic [31:0]                c_abs;
  logic signed [SAMPLE_BITS:0] xsum;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    yv;
  logic [30:0]                s_cl;
  logic signed [31:0]         c_cl;
  logic                       div_wait;

  // Reciprocal division: estimate and remainder correction.
  logic [31:0]                q_est;
  logic [57:0]                w0_num;
  logic [15:0]                w0_lo;
  logic [29:0]                w0_qd;
  logic [15:0]                w0_rem;
  logic [8:0]                 tx_lo;
  logic [7:0]                 t_den;
  logic [16:0]                t_qd;
  logic [8:0]                 t_rem;
  logic [32:0]                tq;

  dbl_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  dbl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .short_op (div_short),
    .num      (div_num),
    .den      (div_den),
    .stat     (div_st),
    .quot     (div_q)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign out_free      = !out_valid || m_axis_tready;
  assign div_wait      = (state == S_B1_WAIT) || (state == S_A1_WAIT) ||
                         (state == S_A2_WAIT);

  // The estimate from a reciprocal multiply is at most two below the true
  // quotient for the angle and at most one below for a Taylor term. The
  // remainder is small, so only its low bits are formed to correct it.
  assign q_est  = prod[63:32];
  assign w0_num = prod[57:0] + {25'd0, W0_HALF};
  assign w0_qd  = {14'd0, q_est[15:0]} * {16'd0, W0_DIVISOR};
  assign w0_rem = w0_lo - w0_qd[15:0];
  assign w0q    = (w0_rem >= {1'b0, W0_DIVISOR, 1'b0}) ? {1'b0, q_est} + 33'd2 :
                  (w0_rem >= {2'b00, W0_DIVISOR})      ? {1'b0, q_est} + 33'd1 :
                                                         {1'b0, q_est};
  assign t_den  = taylor_den(n);
  assign t_qd   = {8'd0, q_est[8:0]} * {9'd0, t_den};
  assign t_rem  = tx_lo - t_qd[8:0];
  assign tq     = (t_rem >= {1'b0, t_den}) ? {1'b0, q_est} + 33'd1 : {1'b0, q_est};

  // Series bookkeeping: odd steps subtract, even steps add.
  assign tsum_upd    = k[0] ? tsum - $signed({2'b00, tq})
                            : tsum + $signed({2'b00, tq});
  assign taylor_last = odd ? (k == 4'd7) : (k == 4'd8);

  // Sine clamps to [0, 1]; cosine to [-1, 1] and is negated in the upper half.
  always_comb begin
    if (tsum_upd < 35'sd0) begin
      s_cl = '0;
    end else if (tsum_upd > $signed({2'b00, ONE_Q30})) begin
      s_cl = ONE_Q30[30:0];
    end else begin
      s_cl = tsum_upd[30:0];
    end
    if (tsum_upd > $signed({2'b00, ONE_Q30})) begin
      c_cl = $signed(ONE_Q30[31:0]);
    end else if (tsum_upd < -$signed({2'b00, ONE_Q30})) begin
      c_cl = -$signed(ONE_Q30[31:0]);
    end else begin
      c_cl = tsum_upd[31:0];
    end
    if (neg_cos) begin
      c_cl = -c_cl;
    end
  end

  assign w0f   = (w0q > PI_HALF) ? PI_Q29 - w0q : w0q;
  assign c_abs = c[31] ? 32'(-c) : 32'(c);
  assign xsum  = {x[SAMPLE_BITS-1], x} + {in2[SAMPLE_BITS-1], in2};
  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign rnd   = acc + RND_HALF;
  assign yv    = rnd >>> COEF_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the operands of the shared multiplier and divider.
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_short  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    rd_v       = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (s_axis_tdata[39:24] == '0) ? S_OUT : S_P_MUL;
        end
      end
      S_P_MUL: begin
        mul_a      = $signed({9'd0, cutoff});
        mul_b      = $signed({17'd0, dt});
        state_next = S_P_CLAMP;
      end
      S_P_CLAMP: state_next = S_W0_MUL;
      S_W0_MUL: begin
        mul_a      = $signed({6'd0, p});
        mul_b      = $signed(PI_Q29);
        state_next = S_W0_REC;
      end
      S_W0_REC: begin
        mul_a      = $signed({1'b0, w0_num[57:26]});
        mul_b      = $signed({1'b0, W0_RECIP});
        state_next = S_W0_FIX;
      end
      S_W0_FIX: state_next = S_T_MUL1;
      S_T_MUL1: begin
        mul_a      = $signed(term);
        mul_b      = $signed({1'b0, t});
        state_next = S_T_MUL2;
      end
      S_T_MUL2: begin
        mul_a      = $signed(prod[62:30]);
        mul_b      = $signed({1'b0, t});
        state_next = S_T_REC;
      end
      S_T_REC: begin
        mul_a      = $signed({1'b0, prod[61:30]});
        mul_b      = $signed({1'b0, taylor_recip(n)});
        state_next = S_T_FIX;
      end
      S_T_FIX: begin
        state_next = (taylor_last && !odd) ? S_A_MUL : S_T_MUL1;
      end
      S_A_MUL: begin
        mul_a      = $signed({2'b00, s});
        mul_b      = $signed(INV_SQRT2);
        state_next = S_ALPHA;
      end
      S_ALPHA: state_next = S_B1_DIV;
      S_B1_DIV, S_A1_DIV, S_A2_DIV: begin
        if (state == S_B1_DIV) begin
          rd_v       = ONE_Q30 - {c[31], c};
          state_next = S_B1_WAIT;
        end else if (state == S_A1_DIV) begin
          rd_v       = {c_abs, 1'b0};
          state_next = S_A1_WAIT;
        end else begin
          rd_v       = ONE_Q30 - {2'b00, alpha};
          state_next = S_A2_WAIT;
        end
        div_start = 1'b1;
        div_num   = ({31'd0, rd_v} << COEF_FRAC_BITS) + {33'd0, den[31:1]};
        div_den   = den;
      end
      S_B1_WAIT: if (div_st.done) state_next = S_A1_DIV;
      S_A1_WAIT: if (div_st.done) state_next = S_A2_DIV;
      S_A2_WAIT: if (div_st.done) state_next = S_M0;
      S_M0: begin
        mul_a      = $signed(b0);
        mul_b      = {{(MUL_W-SAMPLE_BITS-1){xsum[SAMPLE_BITS]}}, xsum};
        state_next = S_M1;
      end
      S_M1: begin
        mul_a      = $signed(b1);
        mul_b      = {{(MUL_W-SAMPLE_BITS){in1[SAMPLE_BITS-1]}}, in1};
        state_next = S_M2;
      end
      S_M2: begin
        mul_a      = na1;
        mul_b      = {{(MUL_W-SAMPLE_BITS){out1[SAMPLE_BITS-1]}}, out1};
        state_next = S_M3;
      end
      S_M3: begin
        mul_a      = na2;
        mul_b      = {{(MUL_W-SAMPLE_BITS){out2[SAMPLE_BITS-1]}}, out2};
        state_next = S_M4;
      end
      S_M4: state_next = S_SAT;
      S_SAT: state_next = S_OUT;
      S_OUT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= CUTOFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cutoff <= cfg_data;
    end
  end

  // History and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in1       <= '0;
      in2       <= '0;
      out1      <= '0;
      out2      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
        in2       <= in1;
        in1       <= x;
        out2      <= out1;
        out1      <= y;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_data <= y;
    end
  end

  // Datapath registers, loaded as the sequencer walks through its states.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          x  <= s_axis_tdata[SAMPLE_BITS-1:0];
          dt <= s_axis_tdata[39:24];
          y  <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
      end
      S_P_CLAMP: begin
        p <= (prod > $signed({33'd0, W0_CLAMP})) ? W0_CLAMP[26:0] : prod[26:0];
      end
      S_W0_REC: begin
        w0_lo <= w0_num[28:13];
      end
      S_W0_FIX: begin
        neg_cos <= (w0q > PI_HALF);
        t       <= {w0f[30:0], 1'b0};
        term    <= {w0f[31:0], 1'b0};
        tsum    <= $signed({2'b00, w0f[31:0], 1'b0});
        n       <= 4'd1;
        k       <= 4'd1;
        odd     <= 1'b1;
      end
      S_T_REC: begin
        tx_lo <= prod[38:30];
      end
      S_T_FIX: begin
        if (taylor_last) begin
          if (odd) begin
            s    <= s_cl;
            term <= ONE_Q30;
            tsum <= $signed({2'b00, ONE_Q30});
            n    <= 4'd0;
            k    <= 4'd1;
            odd  <= 1'b0;
          end else begin
            c <= c_cl;
          end
        end else begin
          term <= tq;
          tsum <= tsum_upd;
          n    <= n + 4'd2;
          k    <= k + 4'd1;
        end
      end
      S_ALPHA: begin
        alpha <= 31'((prod + PROD_W'(ONE_Q30 >> 1)) >>> 30);
        den   <= 32'(ONE_Q30) + {1'b0, 31'((prod + PROD_W'(ONE_Q30 >> 1)) >>> 30)};
      end
      S_B1_WAIT: begin
        if (div_st.done) begin
          b1 <= div_q[32:0];
          b0 <= {1'b0, div_q[32:1]};
        end
      end
      S_A1_WAIT: begin
        if (div_st.done) begin
          na1 <= c[31] ? -$signed(div_q[32:0]) : $signed(div_q[32:0]);
        end
      end
      S_A2_WAIT: begin
        if (div_st.done) begin
          na2 <= -$signed(div_q[32:0]);
        end
      end
      S_M1: acc <= prod_ext;
      S_M2, S_M3, S_M4: acc <= acc + prod_ext;
      S_SAT: begin
        if (yv > SAT_HI) begin
          y <= SAT_HI[SAMPLE_BITS-1:0];
        end else if (yv < SAT_LO) begin
          y <= SAT_LO[SAMPLE_BITS-1:0];
        end else begin
          y <= yv[SAMPLE_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  `DBL_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready)
  `DBL_ASSERT_IMPL(a_div_done_awaited, div_st.done, div_wait)
  `DBL_ASSERT_NEXT(a_out_loaded, state == S_OUT && !m_axis_tvalid, m_axis_tvalid && state == S_IDLE)

endmodule

// ----- tb/tb_dynamic_biquad_lowpass.sv -----
// ----------------------------------------------------------------------------
// tb_dynamic_biquad_lowpass
// Self-checking bench for the variable time step Butterworth low-pass.
// A bit-exact fixed-point model of the filter runs next to the block. Each
// word that the block takes is fed to the model, and each word that leaves is
// compared with the oldest predicted word. Both stream sides idle at random.
// The run covers several cutoff settings, among them zero, the reset value
// and the maximum, and one long output stall that fills the block.
// ----------------------------------------------------------------------------
module tb_dynamic_biquad_lowpass;

  import dbl_pkg::*;

  localparam int STALL_CYCLES = 2500;
  localparam int RANDOM_WORDS = 160;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [23:0] sample, [39:24] time_step
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [23:0] filtered
  logic [23:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CUTOFF_BITS-1:0] cfg_data;

  // Model state: cutoff and the two input and two output history values.
  logic [CUTOFF_BITS-1:0] model_cutoff;
  longint signed hist_in1, hist_in2, hist_out1, hist_out2;

  logic [23:0] filtered_q[$];
  int  mismatches;
  int  unexpected_words;
  int  words_sent;
  int  bypass_words;
  int  saturated_words;
  bit  no_gaps;
  bit  stall_request;

  dynamic_biquad_lowpass i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Truncated Taylor series in Q2.30; odd selects sine, otherwise cosine.
  function automatic longint signed taylor_q30(longint unsigned t, bit odd);
    longint unsigned term;
    longint signed   sum;
    longint unsigned n;
    int              k;
    term = odd ? t : 64'd1 << 30;
    sum  = longint'(term);
    n    = odd ? 1 : 0;
    for (k = 1; k <= (odd ? 7 : 8); k++) begin
      term = ((((term * t) >> 30) * t) >> 30) / ((n + 1) * (n + 2));
      n += 2;
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    return sum;
  endfunction

  // Quotient rounded half up, in Q2.30.
  function automatic longint unsigned coef_div(longint unsigned num, longint unsigned den);
    return ((num << COEF_FRAC_BITS) + (den >> 1)) / den;
  endfunction

  // Computes the next filtered word and advances the history.
  function automatic logic [23:0] lowpass_next(logic signed [23:0] smp, logic [15:0] dt);
    longint signed   x, y, s, c, a1, hi, acc_term;
    longint unsigned p, w0, t, alpha, den, b1, b0, a1m, a2, lo;
    longint unsigned one, clamp, pi;
    longint signed   lim_hi, lim_lo;
    bit              neg_cos;
    x = smp;
    one = 64'd1 << 30;
    clamp = longint'(W0_CLAMP);
    pi = longint'(PI_Q29);
    lim_hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    lim_lo = -lim_hi - 1;
    if (dt != 0) begin
      p = longint'(model_cutoff) * longint'(dt);
      if (p > clamp) p = clamp;
      w0 = (p * pi + (clamp >> 1)) / clamp;
      neg_cos = 1'b0;
      // Fold the angle into the first quadrant; cosine flips sign.
      if (w0 > (pi >> 1)) begin
        w0 = pi - w0;
        neg_cos = 1'b1;
      end
      t = w0 << 1;
      s = taylor_q30(t, 1'b1);
      c = taylor_q30(t, 1'b0);
      if (s < 0) s = 0;
      if (s > longint'(one)) s = one;
      if (c < -longint'(one)) c = -longint'(one);
      if (c > longint'(one)) c = one;
      if (neg_cos) c = -c;
      alpha = (longint'(s) * longint'(INV_SQRT2) + (64'd1 << 29)) >> 30;
      den = one + alpha;
      b1 = coef_div(longint'(one) - c, den);
      b0 = b1 >> 1;
      a1m = coef_div(2 * (c < 0 ? -c : c), den);
      a1 = (c >= 0) ? -longint'(a1m) : longint'(a1m);
      a2 = coef_div(one - alpha, den);
      // Exact accumulation: integer parts floor-shifted, fractions summed apart.
      hi = 0;
      lo = 0;
      for (int i = 0; i < 4; i++) begin
        case (i)
          0: acc_term = longint'(b0) * (x + hist_in2);
          1: acc_term = longint'(b1) * hist_in1;
          2: acc_term = -a1 * hist_out1;
          default: acc_term = -longint'(a2) * hist_out2;
        endcase
        hi += acc_term >>> COEF_FRAC_BITS;
        lo += longint'(acc_term) & ((64'd1 << COEF_FRAC_BITS) - 1);
      end
      y = hi + longint'((lo + (64'd1 << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS);
      if (y > lim_hi || y < lim_lo) saturated_words++;
      if (y > lim_hi) y = lim_hi;
      if (y < lim_lo) y = lim_lo;
    end else begin
      y = x;
      bypass_words++;
    end
    hist_in2 = hist_in1;
    hist_in1 = x;
    hist_out2 = hist_out1;
    hist_out1 = y;
    return y[23:0];
  endfunction

  // Offers one word after an optional random gap and waits until it is taken.
  task automatic send_word(logic [23:0] smp, logic [15:0] dt);
    int gap;
    gap = (!no_gaps && $urandom_range(99) < 20) ? $urandom_range(6, 1) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt, smp};
    do @(posedge clk); while (!s_axis_tready);
    filtered_q.push_back(lowpass_next(smp, dt));
    words_sent++;
  endtask

  // Stops offering and waits until every predicted word has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cutoff(logic [CUTOFF_BITS-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_cutoff = value;
  endtask

  // Step choice: bypass, a step that keeps the angle at or below pi, or any step.
  function automatic logic [15:0] random_step();
    int unsigned bound;
    int unsigned pick;
    pick = $urandom_range(99);
    bound = (model_cutoff == 0) ? 65535 : 128000000 / model_cutoff;
    if (bound > 65535) bound = 65535;
    if (bound < 1) bound = 1;
    if (pick < 20) return 16'd0;
    if (pick < 65) return 16'($urandom_range(bound, 1));
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [23:0] random_sample();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  // Field extremes at the reset cutoff, zero cutoff growth and a full scale cutoff.
  task automatic test_directed();
    send_word(24'h7FFFFF, 16'd1);
    send_word(24'h7FFFFF, 16'd0);
    send_word(24'h800000, 16'd65535);
    send_word(24'h000000, 16'd50000);  // angle exactly pi at the reset cutoff
    send_word(24'h800000, 16'd49999);
    send_word(24'h7FFFFF, 16'd50001);
    send_word(24'h123456, 16'd100);
    send_word(24'hFEDCBA, 16'd0);
    write_cutoff(24'd0);
    // With no cutoff the output extrapolates the last two and saturates.
    send_word(24'h000000, 16'd0);
    send_word(24'h400000, 16'd0);
    repeat (4) send_word(24'h000000, 16'd7);
    send_word(24'h7FFFFF, 16'd65535);
    write_cutoff(24'hFFFFFF);
    send_word(24'h7FFFFF, 16'd1);
    send_word(24'h800000, 16'd65535);
    send_word(24'h7FFFFF, 16'd7);
    send_word(24'h800000, 16'd0);
    send_word(24'h555555, 16'hAAAA);
    send_word(24'hAAAAAA, 16'h5555);
  endtask

  // One phase of random words at the given cutoff.
  task automatic test_random_phase(logic [CUTOFF_BITS-1:0] value, bit steady);
    write_cutoff(value);
    no_gaps = steady;
    repeat (RANDOM_WORDS) send_word(random_sample(), random_step());
    no_gaps = 1'b0;
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_output_stall();
    drain();
    stall_request = 1'b1;
    repeat (6) send_word(random_sample(), random_step());
  endtask

  // Output side: random idling, or the long hold when one is asked for.
  initial begin
    int hold_left;
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_request) begin
        stall_request = 1'b0;
        hold_left = STALL_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 20);
      end
    end
  end

  // Compares every word that leaves the block with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        unexpected_words++;
        $display("unexpected output word %h", m_axis_tdata);
      end else begin
        logic [23:0] want;
        want = filtered_q.pop_front();
        if (m_axis_tdata !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("filtered mismatch: expected %h got %h", want, m_axis_tdata);
        end
      end
    end
  end

  initial begin
    #(8 * 40_000_000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    no_gaps       = 1'b0;
    stall_request = 1'b0;
    mismatches = 0;
    unexpected_words = 0;
    words_sent = 0;
    bypass_words = 0;
    saturated_words = 0;
    model_cutoff = CUTOFF_RESET;
    hist_in1 = 0;
    hist_in2 = 0;
    hist_out1 = 0;
    hist_out2 = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_phase(CUTOFF_RESET, 1'b0);
    test_random_phase(24'd1, 1'b0);
    test_random_phase(24'd25600, 1'b1);
    test_random_phase(24'hFFFFFF, 1'b0);
    test_random_phase(24'd0, 1'b0);
    test_random_phase(24'($urandom_range(4000, 1)), 1'b0);
    test_output_stall();
    test_random_phase(24'($urandom), 1'b0);
    test_random_phase(24'd256000, 1'b0);
    test_random_phase(24'($urandom_range(300, 1)), 1'b0);
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d words over 11 cutoff settings and one long output stall",
             words_sent);
    $display("%0d bypass words, %0d saturated outputs, %0d mismatches",
             bypass_words, saturated_words, mismatches);
    if (mismatches == 0 && unexpected_words == 0 && filtered_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- dynamic_biquad_lowpass.f -----
+incdir+src
src/dbl_pkg.sv
src/dbl_mul.sv
src/dbl_div.sv
src/dynamic_biquad_lowpass.sv
tb/tb_dynamic_biquad_lowpass.sv
